/* rtl/srb_pkg.sv */
// shared constants and types for the sequenced retransmit buffer
`timescale 1ns / 1ps
package srb_pkg;
    localparam int DEPTH = 32;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [5:0] MAX_ENTRIES_RESET = 6'd20;

    localparam logic [2:0] K_NEXT  = 3'd0;
    localparam logic [2:0] K_CUR   = 3'd1;
    localparam logic [2:0] K_ADD   = 3'd2;
    localparam logic [2:0] K_DEL   = 3'd3;
    localparam logic [2:0] K_FIRST = 3'd4;
    localparam logic [2:0] K_GET   = 3'd5;
    localparam logic [2:0] K_LIST  = 3'd6;

    typedef struct packed {
        logic         we;
        logic [AW-1:0] waddr;
        logic [31:0]  wseq;
        logic [31:0]  wpay;
        logic [AW-1:0] raddr;
    } t_mem_req;
endpackage

/* rtl/srb_entry_ram.sv */
// entry store: sequence and payload, one write and one registered read port
`timescale 1ns / 1ps
module srb_entry_ram (
    input  logic                 i_clk,
    input  srb_pkg::t_mem_req    i_req,
    output logic [31:0]          o_rseq,
    output logic [31:0]          o_rpay
);
    import srb_pkg::*;
    logic [63:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= {i_req.wseq, i_req.wpay};
        end
        {o_rseq, o_rpay} <= mem[i_req.raddr];
    end
endmodule

/* rtl/sequenced_retransmit_buffer.sv */
// top level: command sequencer around the entry store
// channel | direction | handshake               | payload
// command | in        | start / busy            | kind, keepalive_req, seq_in, payload_in
// result  | out       | o_strobe (no stall)     | seq_out, payload_out, found, entry_count, last
// config  | in        | i_cfg_valid/o_cfg_ready | max_entries
// one word in, then busy until its last result strobe has gone out; items run one at a time
// next_seq, current_seq and unused kinds answer straight from idle; a list of no entries gives no strobe
// get and list walk one entry a cycle through the single read port
// an evicting add or a hitting delete shifts the tail down entry by entry, reading each then writing it one place lower
// reset clears counter, flag and count; the store needs no clearing
// results cannot be stalled and o_cfg_ready is always high
`timescale 1ns / 1ps
module sequenced_retransmit_buffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic        i_keepalive_req,
    input  logic [31:0] i_seq_in,
    input  logic [31:0] i_payload_in,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_max_entries,
    output logic        o_strobe,
    output logic [31:0] o_seq_out,
    output logic [31:0] o_payload_out,
    output logic        o_found,
    output logic [5:0]  o_entry_count,
    output logic        o_last
);
    import srb_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_LIST  = 3'd3;
    localparam logic [2:0] S_FIRST = 3'd4;
    localparam logic [2:0] S_EVICT = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [31:0]   r_ctr, n_ctr;
    logic          r_ka, n_ka;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [5:0]    r_max;
    logic [2:0]    r_kind, n_kind;
    logic [31:0]   r_seq, n_seq;
    logic [31:0]   r_pay, n_pay;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_rdv, n_rdv;
    logic [CW-1:0] r_ridx, n_ridx;

    logic          r_stb, n_stb;
    logic [31:0]   r_os, n_os, r_op, n_op;
    logic          r_of, n_of, r_ol, n_ol;
    logic [5:0]    r_oc, n_oc;

    t_mem_req      req;
    logic [31:0]   rseq, rpay;
    logic [CW-1:0] limit;

    srb_entry_ram u_ram (.i_clk(i_clk), .i_req(req), .o_rseq(rseq), .o_rpay(rpay));

    assign busy          = (r_state != S_IDLE) || r_stb;
    assign o_cfg_ready   = 1'b1;
    assign o_strobe      = r_stb;
    assign o_seq_out     = r_os;
    assign o_payload_out = r_op;
    assign o_found       = r_of;
    assign o_entry_count = r_oc;
    assign o_last        = r_ol;

    always_comb begin
        if (r_max == 6'd0 || 32'(r_max) > 32'(DEPTH)) begin
            limit = CW'(DEPTH);
        end else begin
            limit = CW'(r_max);
        end
    end

    always_comb begin
        n_state = r_state; n_ctr = r_ctr; n_ka = r_ka; n_cnt = r_cnt;
        n_kind = r_kind; n_seq = r_seq; n_pay = r_pay; n_idx = r_idx;
        n_rdv = 1'b0; n_ridx = r_ridx;
        n_stb = 1'b0; n_os = 32'd0; n_op = 32'd0; n_of = 1'b0; n_ol = 1'b1;
        n_oc = 6'(r_cnt);
        req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start && !busy) begin
                    n_kind = i_kind; n_seq = i_seq_in; n_pay = i_payload_in;
                    n_idx = '0;
                    unique case (i_kind)
                        K_NEXT: begin
                            if (r_ka) begin
                                if (!i_keepalive_req) n_ka = 1'b0;
                                n_os = r_ctr;
                            end else begin
                                if (i_keepalive_req) n_ka = 1'b1;
                                n_ctr = (r_ctr == 32'hFFFF_FFFF) ? 32'd1 : r_ctr + 32'd1;
                                n_os = n_ctr;
                            end
                            n_stb = 1'b1;
                        end
                        K_CUR: begin
                            if (r_ctr == 32'd0) n_ctr = 32'd1;
                            n_os = n_ctr;
                            n_stb = 1'b1;
                        end
                        K_ADD: begin
                            if (r_cnt + CW'(1) > limit || r_cnt >= CW'(DEPTH)) begin
                                if (r_cnt == '0) begin
                                    n_state = S_DONE;
                                end else begin
                                    n_state = S_EVICT;
                                end
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        K_DEL, K_GET: begin
                            n_state = (r_cnt == '0) ? S_DONE : S_SCAN;
                        end
                        K_FIRST: begin
                            n_state = (r_cnt == '0) ? S_DONE : S_FIRST;
                        end
                        K_LIST: begin
                            n_state = (r_cnt == '0) ? S_IDLE : S_LIST;
                        end
                        default: begin
                            n_stb = 1'b1;
                        end
                    endcase
                end
            end
            S_EVICT: begin
                // drop oldest by shifting down from position zero
                n_ridx = '0; n_idx = '0;
                n_state = S_SHIFT;
            end
            S_FIRST: begin
                req.raddr = '0;
                if (r_rdv) begin
                    n_os = rseq; n_op = rpay; n_of = 1'b1; n_stb = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_rdv = 1'b1;
                end
            end
            S_SCAN: begin
                req.raddr = r_idx[AW-1:0];
                if (r_rdv && rseq == r_seq) begin
                    if (r_kind == K_GET) begin
                        n_os = rseq; n_op = rpay; n_of = 1'b1; n_stb = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_os = rseq; n_op = rpay; n_of = 1'b1;
                        n_idx = r_ridx;
                        n_state = S_SHIFT;
                    end
                end else if (r_rdv && r_ridx + CW'(1) >= r_cnt) begin
                    n_stb = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    if (r_idx + CW'(1) < r_cnt) n_idx = r_idx + CW'(1);
                    n_rdv = (r_idx < r_cnt);
                    n_ridx = r_idx;
                end
            end
            S_SHIFT: begin
                // hold result; r_idx is the hole, read hole+1 then write hole
                n_os = r_os; n_op = r_op; n_of = r_of;
                if (r_idx + CW'(1) >= r_cnt) begin
                    n_cnt = r_cnt - CW'(1);
                    if (r_kind == K_ADD) begin
                        n_state = S_DONE;
                    end else begin
                        n_oc = 6'(n_cnt); n_stb = 1'b1; n_state = S_IDLE;
                    end
                end else begin
                    req.raddr = AW'(r_idx + CW'(1));
                    if (r_rdv) begin
                        req.we = 1'b1; req.waddr = r_idx[AW-1:0];
                        req.wseq = rseq; req.wpay = rpay;
                        n_idx = r_idx + CW'(1);
                    end else begin
                        n_rdv = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (r_kind == K_ADD) begin
                    if (r_cnt < CW'(DEPTH)) begin
                        req.we = 1'b1; req.waddr = r_cnt[AW-1:0];
                        req.wseq = r_seq; req.wpay = r_pay;
                        n_cnt = r_cnt + CW'(1);
                    end
                end
                n_oc = 6'(n_cnt); n_stb = 1'b1; n_state = S_IDLE;
            end
            S_LIST: begin
                req.raddr = r_idx[AW-1:0];
                if (r_rdv) begin
                    n_os = rseq; n_stb = 1'b1;
                    n_ol = (r_ridx + CW'(1) == r_cnt);
                    if (n_ol) n_state = S_IDLE;
                end
                if (r_idx < r_cnt) begin
                    n_rdv = 1'b1; n_ridx = r_idx; n_idx = r_idx + CW'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ctr <= '0; r_ka <= 1'b0; r_cnt <= '0;
            r_max <= MAX_ENTRIES_RESET; r_stb <= 1'b0; r_rdv <= 1'b0;
        end else begin
            r_state <= n_state; r_ctr <= n_ctr; r_ka <= n_ka; r_cnt <= n_cnt;
            r_stb <= n_stb; r_rdv <= n_rdv;
            if (i_cfg_valid && o_cfg_ready) r_max <= i_cfg_max_entries;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind; r_seq <= n_seq; r_pay <= n_pay; r_idx <= n_idx;
        r_ridx <= n_ridx;
        r_os <= n_os; r_op <= n_op; r_of <= n_of; r_ol <= n_ol; r_oc <= n_oc;
    end
endmodule
